// ===== rtl/core/hsv_pkg.sv =====
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; every other file in rtl/core imports this package.
package hsv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FIELD_W   = FRAC_BITS + 1;
    localparam int CHAN_W    = 8;

    // 1.0 in the input fixed-point format.
    localparam logic [FIELD_W-1:0] FIX_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // The six hue sectors, named after the color at their start.
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] brightness;
    } hsv_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_result_t;

    // After sector split: sector, hue fraction, clamped s and v.
    typedef struct packed {
        sector_t              sector;
        logic [FRAC_BITS-1:0] frac;
        logic [FIELD_W-1:0]   sat;
        logic [FIELD_W-1:0]   val;
    } split_t;

    // After the first multiply stage: p and the two inner products.
    typedef struct packed {
        sector_t            sector;
        logic [FIELD_W-1:0] val;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] mq;
        logic [FIELD_W-1:0] mt;
    } inner_t;

    // After the second multiply stage: all candidate channel levels.
    typedef struct packed {
        sector_t            sector;
        logic [FIELD_W-1:0] val;
        logic [FIELD_W-1:0] p;
        logic [FIELD_W-1:0] q;
        logic [FIELD_W-1:0] t;
    } levels_t;

    // floor(x * 255 / ONE) for x in 0..ONE, done as (x << 8) - x.
    function automatic logic [CHAN_W-1:0] to_channel(input logic [FIELD_W-1:0] x);
        logic [FIELD_W+CHAN_W-1:0] prod;
        prod = {x, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, x};
        return prod[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    endfunction

endpackage

// ===== rtl/core/hsv_sector.sv =====
// First pipeline stage: clamps s and v and splits hue into sector and fraction.
// Depends on hsv_pkg.
module hsv_sector (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  hsv_pkg::hsv_req_t req,
    output logic              out_valid,
    output hsv_pkg::split_t   out
);
    import hsv_pkg::*;

    localparam int H6_W = FIELD_W + 3;

    logic              valid_reg;
    split_t            data_reg;
    split_t            data_next;
    logic [H6_W-1:0]   h6;
    logic [H6_W-FRAC_BITS-1:0] whole;
    logic [H6_W-FRAC_BITS-1:0] wrapped;

    always_comb
    begin
        // hue * 6 as (hue << 2) + (hue << 1).
        h6 = {1'b0, req.hue, 2'b00} + {2'b00, req.hue, 1'b0};
        whole = h6[H6_W-1:FRAC_BITS];
        // The whole part never reaches 12, so one subtract wraps it.
        wrapped = (whole >= (H6_W-FRAC_BITS)'(6)) ? whole - (H6_W-FRAC_BITS)'(6) : whole;
        data_next.sector = sector_t'(wrapped[2:0]);
        data_next.frac   = h6[FRAC_BITS-1:0];
        data_next.sat    = (req.saturation > FIX_ONE) ? FIX_ONE : req.saturation;
        data_next.val    = (req.brightness > FIX_ONE) ? FIX_ONE : req.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out       = data_reg;

endmodule

// ===== rtl/core/hsv_products.sv =====
// Second and third pipeline stages: the two rounds of fixed-point multiplies
// that form p, q and t. Depends on hsv_pkg.
module hsv_products (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  hsv_pkg::split_t  in,
    output logic             out_valid,
    output hsv_pkg::levels_t out
);
    import hsv_pkg::*;

    localparam int PROD_W = 2 * FIELD_W;

    logic    inner_valid_reg;
    inner_t  inner_reg;
    inner_t  inner_next;
    logic    levels_valid_reg;
    levels_t levels_reg;
    levels_t levels_next;

    logic [FIELD_W-1:0] one_minus_f;
    logic [PROD_W-1:0]  prod_p;
    logic [PROD_W-1:0]  prod_mq;
    logic [PROD_W-1:0]  prod_mt;
    logic [PROD_W-1:0]  prod_q;
    logic [PROD_W-1:0]  prod_t;

    // Inner products f*s and (1-f)*s, and the outer product for p.
    always_comb
    begin
        one_minus_f = FIX_ONE - {1'b0, in.frac};
        prod_p  = PROD_W'(in.val) * PROD_W'(FIX_ONE - in.sat);
        prod_mq = PROD_W'({1'b0, in.frac}) * PROD_W'(in.sat);
        prod_mt = PROD_W'(one_minus_f) * PROD_W'(in.sat);
        inner_next.sector = in.sector;
        inner_next.val    = in.val;
        inner_next.p      = prod_p[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        inner_next.mq     = prod_mq[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        inner_next.mt     = prod_mt[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    end

    // Outer products for q and t.
    always_comb
    begin
        prod_q = PROD_W'(inner_reg.val) * PROD_W'(FIX_ONE - inner_reg.mq);
        prod_t = PROD_W'(inner_reg.val) * PROD_W'(FIX_ONE - inner_reg.mt);
        levels_next.sector = inner_reg.sector;
        levels_next.val    = inner_reg.val;
        levels_next.p      = inner_reg.p;
        levels_next.q      = prod_q[FRAC_BITS+FIELD_W-1:FRAC_BITS];
        levels_next.t      = prod_t[FRAC_BITS+FIELD_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_valid_reg  <= 1'b0;
            levels_valid_reg <= 1'b0;
        end
        else
        begin
            inner_valid_reg  <= in_valid;
            levels_valid_reg <= inner_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            inner_reg <= inner_next;
        end
        if (inner_valid_reg)
        begin
            levels_reg <= levels_next;
        end
    end

    assign out_valid = levels_valid_reg;
    assign out       = levels_reg;

endmodule

// ===== rtl/core/hsv_channel.sv =====
// Last pipeline stage: picks each channel's level by sector and scales it
// to 0..255. Depends on hsv_pkg.
module hsv_channel (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  hsv_pkg::levels_t     in,
    output logic                 out_valid,
    output hsv_pkg::rgb_result_t out
);
    import hsv_pkg::*;

    logic               valid_reg;
    rgb_result_t        rgb_reg;
    rgb_result_t        rgb_next;
    logic [FIELD_W-1:0] r_lvl;
    logic [FIELD_W-1:0] g_lvl;
    logic [FIELD_W-1:0] b_lvl;

    always_comb
    begin
        case (in.sector)
            SEC_RED:
            begin
                r_lvl = in.val; g_lvl = in.t;   b_lvl = in.p;
            end
            SEC_YELLOW:
            begin
                r_lvl = in.q;   g_lvl = in.val; b_lvl = in.p;
            end
            SEC_GREEN:
            begin
                r_lvl = in.p;   g_lvl = in.val; b_lvl = in.t;
            end
            SEC_CYAN:
            begin
                r_lvl = in.p;   g_lvl = in.q;   b_lvl = in.val;
            end
            SEC_BLUE:
            begin
                r_lvl = in.t;   g_lvl = in.p;   b_lvl = in.val;
            end
            default:
            begin
                r_lvl = in.val; g_lvl = in.p;   b_lvl = in.q;
            end
        endcase
        rgb_next.red   = to_channel(r_lvl);
        rgb_next.green = to_channel(g_lvl);
        rgb_next.blue  = to_channel(b_lvl);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign out_valid = valid_reg;
    assign out       = rgb_reg;

endmodule

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level. Depends on hsv_pkg, hsv_sector,
// hsv_products and hsv_channel.
// A taken request passes through the sector, inner, levels and channel
// registers in that order, and its result is shown with done high.
// Throughput: one request per cycle; busy is always low.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only.
module hsv_to_rgb_converter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  hsv_pkg::hsv_req_t    hsv,
    output logic                 done,
    output hsv_pkg::rgb_result_t rgb
);
    import hsv_pkg::*;

    // The pipeline has four register stages:
    //   1. clamp s and v, split hue*6 into sector and fraction f;
    //   2. multiply: p = v(1-s), and the inner terms f*s and (1-f)*s;
    //   3. multiply: q = v(1-fs), t = v(1-(1-f)s);
    //   4. select the channel levels by sector and scale by 255.
    // Each stage carries a valid bit alongside its data. The receiver must take
    // every result in the cycle it is shown; the block does not enforce this. Nothing
    // ever stalls and the block can take a new request on every clock edge.

    logic    accept;
    logic    split_valid;
    split_t  split_data;
    logic    levels_valid;
    levels_t levels_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    hsv_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .req       (hsv),
        .out_valid (split_valid),
        .out       (split_data)
    );

    hsv_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in        (split_data),
        .out_valid (levels_valid),
        .out       (levels_data)
    );

    hsv_channel u_channel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (levels_valid),
        .in        (levels_data),
        .out_valid (done),
        .out       (rgb)
    );

    // Every accepted request comes out of the pipeline with done high.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
    else $error("request did not produce a result after four cycles");

    // A result only appears for a request that was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
    else $error("result appeared without a matching request");

    // Zero saturation gives a gray: all three channels equal.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(hsv.saturation == '0, 4)
        |-> (rgb.red == rgb.green) && (rgb.green == rgb.blue))
    else $error("zero saturation did not give equal channels");

    // Zero brightness gives black.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(hsv.brightness == '0, 4)
        |-> (rgb.red == '0) && (rgb.green == '0) && (rgb.blue == '0))
    else $error("zero brightness did not give black");

endmodule
